### sv/pafa_pkg.sv
// ============================================================================
// pafa_pkg
// Shared types and codes for the paragraph arena first-fit allocator.
// ============================================================================
package pafa_pkg;

    localparam int POS_W  = 14;
    localparam int SIZE_W = 12;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic              term;
        logic [15:0]       owner;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] owner_id;
        logic [11:0] want_paras;
        logic [11:0] block_data_para;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] granted_data_para;
        logic [11:0] largest_free;
        logic [12:0] freed_count;
    } res_item_t;

    localparam logic [2:0] CMD_INIT     = 3'd0;
    localparam logic [2:0] CMD_CLAIM    = 3'd1;
    localparam logic [2:0] CMD_ALLOC    = 3'd2;
    localparam logic [2:0] CMD_FREE     = 3'd3;
    localparam logic [2:0] CMD_RESIZE   = 3'd4;
    localparam logic [2:0] CMD_FREE_OWN = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INSUFF    = 3'd1;
    localparam logic [2:0] ST_BAD_BLOCK = 3'd2;
    localparam logic [2:0] ST_CORRUPT   = 3'd3;
    localparam logic [2:0] ST_REFUSED   = 3'd4;

    localparam logic [15:0] OWNER_FREE = 16'h0000;
    localparam logic [15:0] OWNER_ANY  = 16'hFFFF;

    localparam logic [12:0] ARENA_RESET = 13'd4096;

endpackage

### sv/pafa_hdr_mem.sv
// ============================================================================
// pafa_hdr_mem
// Header store: one write port, one read port, registered read data.
// ============================================================================
module pafa_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  pafa_pkg::hdr_t wdata,
    input  logic [AW-1:0] raddr,
    output pafa_pkg::hdr_t rdata
);
    import pafa_pkg::*;

    hdr_t mem [DEPTH];

    // A read and a write to the same entry in one cycle return the old entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/paragraph_arena_first_fit_allocator_unit.sv
// ============================================================================
// paragraph_arena_first_fit_allocator_unit
// Header chain allocator over a paragraph arena, driven by a command sequencer.
// ============================================================================
// Usage: a command item enters on cmd_valid/cmd_item and is taken at an edge
// where cmd_stall is low. The block works on one command at a time and holds
// cmd_stall high from acceptance until the result item is loaded into the
// output register. The result item leaves on res_valid/res_item and stays
// until an edge at which res_stall is low; a new command may be taken while
// the previous result still waits. The arena size register is written on
// cfg_valid/cfg_data, and cfg_ready is always high.
// Every header visit goes through the synchronous header memory (address,
// then data). A valid command other than init first walks the whole chain
// to check its integrity, then makes its own walk; alloc and free commands
// coalesce adjacent free blocks, as resize and free-owner commands may
// too. Init writes a single header. The header memory walk sets the rate.
// Reset clears the sequencer and res_valid and sets the arena size to
// 4096 paragraphs; the header memory is not cleared and must be built by init.
// ============================================================================
module paragraph_arena_first_fit_allocator_unit #(
    parameter int ARENA_DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  pafa_pkg::cmd_item_t cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output pafa_pkg::res_item_t res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [12:0]         cfg_data
);
    import pafa_pkg::*;

    localparam int AW = (ARENA_DEPTH > 1) ? $clog2(ARENA_DEPTH) : 1;

    typedef enum logic [19:0] {
        S_IDLE    = 20'b00000000000000000001,
        S_INIT_W  = 20'b00000000000000000010,
        S_INT_RD  = 20'b00000000000000000100,
        S_INT_EV  = 20'b00000000000000001000,
        S_CLM_RD  = 20'b00000000000000010000,
        S_CLM_EV  = 20'b00000000000000100000,
        S_COA_RD  = 20'b00000000000001000000,
        S_COA_EV  = 20'b00000000000010000000,
        S_COA_NEV = 20'b00000000000100000000,
        S_ALC_RD  = 20'b00000000001000000000,
        S_ALC_EV  = 20'b00000000010000000000,
        S_SPL_W2  = 20'b00000000100000000000,
        S_ISH_RD  = 20'b00000001000000000000,
        S_ISH_EV  = 20'b00000010000000000000,
        S_BLK_RD  = 20'b00000100000000000000,
        S_BLK_EV  = 20'b00001000000000000000,
        S_RSZ_NEV = 20'b00010000000000000000,
        S_FO_RD   = 20'b00100000000000000000,
        S_FO_EV   = 20'b01000000000000000000,
        S_RESP    = 20'b10000000000000000000
    } state_t;

    function automatic logic in_arena(input pos_t p);
        return ({18'd0, p} < 32'(ARENA_DEPTH));
    endfunction

    function automatic logic [AW-1:0] to_addr(input pos_t p);
        return AW'({18'd0, p});
    endfunction

    state_t      state_reg, state_next;
    logic [12:0] arena_reg, arena_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] owner_reg, owner_next;
    logic [11:0] want_reg, want_next;
    logic [12:0] t_reg, t_next;
    pos_t        p_reg, p_next;
    pos_t        hp_reg, hp_next;
    hdr_t        h_reg, h_next;
    logic [2:0]  st_reg, st_next;
    logic [11:0] granted_reg, granted_next;
    logic [11:0] largest_reg, largest_next;
    logic [12:0] freed_reg, freed_next;
    logic        res_valid_reg, res_valid_next;
    res_item_t   res_item_reg, res_item_next;
    logic        rd_ok_reg;

    pos_t  rd_pos, wr_pos;
    logic  wr_en;
    hdr_t  wr_hdr, rdata, hq;

    pos_t        t_pos, h_span, h_end, hp_end, m_next, n_next, alc_r, rsz_r;
    logic [11:0] m_size, lg;
    logic [12:0] comb13, t_eff;
    logic        accept, coa_stop;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Entries beyond the memory read as an all-zero header.
    assign hq     = rd_ok_reg ? rdata : '0;
    assign t_pos  = {1'b0, t_reg};
    assign h_span = {2'b00, hq.size} + 14'd1;
    assign h_end  = p_reg + h_span;
    assign hp_end = hp_reg + h_span;
    assign m_size = h_reg.size + 12'd1 + hq.size;
    assign m_next = p_reg + 14'd1 + {2'b00, m_size};
    assign n_next = hp_reg + h_span;
    assign alc_r  = p_reg + 14'd1 + {2'b00, want_reg};
    assign rsz_r  = hp_reg + 14'd1 + {2'b00, want_reg};
    assign comb13 = {1'b0, h_reg.size} + 13'd1 + {1'b0, hq.size};
    assign lg     = (hq.owner == OWNER_FREE && hq.size > largest_reg) ? hq.size : largest_reg;
    assign t_eff  = ({19'd0, arena_reg} > 32'(ARENA_DEPTH)) ? 13'(ARENA_DEPTH) : arena_reg;
    assign coa_stop = hq.term || (hp_reg >= t_pos);

    pafa_hdr_mem #(
        .DEPTH(ARENA_DEPTH),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (wr_en && in_arena(wr_pos)),
        .waddr(to_addr(wr_pos)),
        .wdata(wr_hdr),
        .raddr(to_addr(rd_pos)),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        arena_next     = arena_reg;
        cmd_next       = cmd_reg;
        owner_next     = owner_reg;
        want_next      = want_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        hp_next        = hp_reg;
        h_next         = h_reg;
        st_next        = st_reg;
        granted_next   = granted_reg;
        largest_next   = largest_reg;
        freed_next     = freed_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;
        rd_pos         = p_reg;
        wr_en          = 1'b0;
        wr_pos         = p_reg;
        wr_hdr         = hq;

        if (cfg_valid)
        begin
            arena_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd_item.command;
                    owner_next   = cmd_item.owner_id;
                    want_next    = cmd_item.want_paras;
                    hp_next      = {2'b00, cmd_item.block_data_para} - 14'd1;
                    t_next       = t_eff;
                    p_next       = '0;
                    st_next      = ST_OK;
                    granted_next = '0;
                    largest_next = '0;
                    freed_next   = '0;
                    if (t_eff == 13'd0 && cmd_item.command <= CMD_FREE_OWN)
                    begin
                        st_next    = ST_CORRUPT;
                        state_next = S_RESP;
                    end
                    else if (cmd_item.command == CMD_INIT)
                    begin
                        state_next = S_INIT_W;
                    end
                    else if (cmd_item.command > CMD_FREE_OWN)
                    begin
                        st_next    = ST_BAD_BLOCK;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_INT_RD;
                    end
                end
            end
            S_INIT_W:
            begin
                wr_en      = 1'b1;
                wr_pos     = '0;
                wr_hdr     = '{term: 1'b1, owner: OWNER_FREE, size: 12'(t_reg - 13'd1)};
                state_next = S_RESP;
            end
            S_INT_RD:
            begin
                if (p_reg >= t_pos)
                begin
                    st_next    = ST_CORRUPT;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_INT_EV;
                end
            end
            S_INT_EV:
            begin
                if ({1'b0, hq.size} >= t_reg || h_end > t_pos
                    || (hq.term && h_end != t_pos))
                begin
                    st_next    = ST_CORRUPT;
                    state_next = S_RESP;
                end
                else if (!hq.term)
                begin
                    p_next     = h_end;
                    state_next = S_INT_RD;
                end
                else
                begin
                    // Chain is intact: start the command's own work.
                    p_next = '0;
                    case (cmd_reg)
                        CMD_CLAIM:  state_next = S_CLM_RD;
                        CMD_ALLOC:  state_next = S_COA_RD;
                        CMD_FREE,
                        CMD_RESIZE:
                        begin
                            if (hp_reg == {POS_W{1'b1}})
                            begin
                                st_next    = ST_BAD_BLOCK;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_ISH_RD;
                            end
                        end
                        CMD_FREE_OWN:
                        begin
                            state_next = (owner_reg == OWNER_FREE) ? S_RESP : S_FO_RD;
                        end
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_CLM_RD:
            begin
                rd_pos     = '0;
                state_next = S_CLM_EV;
            end
            S_CLM_EV:
            begin
                if (!hq.term || h_span != t_pos)
                begin
                    st_next = ST_REFUSED;
                end
                else
                begin
                    wr_en  = 1'b1;
                    wr_pos = '0;
                    wr_hdr = '{term: hq.term, owner: owner_reg, size: hq.size};
                end
                state_next = S_RESP;
            end
            S_COA_RD:
            begin
                if (p_reg >= t_pos)
                begin
                    p_next     = '0;
                    state_next = (cmd_reg == CMD_ALLOC) ? S_ALC_RD : S_RESP;
                end
                else
                begin
                    state_next = S_COA_EV;
                end
            end
            S_COA_EV:
            begin
                h_next = hq;
                if (hq.term)
                begin
                    p_next     = '0;
                    state_next = (cmd_reg == CMD_ALLOC) ? S_ALC_RD : S_RESP;
                end
                else
                begin
                    rd_pos     = h_end;
                    hp_next    = h_end;
                    state_next = S_COA_NEV;
                end
            end
            S_COA_NEV:
            begin
                // h_reg is the header at p_reg, hq the one that follows it.
                if (h_reg.owner == OWNER_FREE && hq.owner == OWNER_FREE)
                begin
                    wr_en  = 1'b1;
                    wr_pos = p_reg;
                    wr_hdr = '{term: hq.term, owner: h_reg.owner, size: m_size};
                    h_next = wr_hdr;
                    if (hq.term)
                    begin
                        p_next     = '0;
                        state_next = (cmd_reg == CMD_ALLOC) ? S_ALC_RD : S_RESP;
                    end
                    else
                    begin
                        rd_pos  = m_next;
                        hp_next = m_next;
                    end
                end
                else
                begin
                    p_next = hp_reg;
                    h_next = hq;
                    if (coa_stop)
                    begin
                        p_next     = '0;
                        state_next = (cmd_reg == CMD_ALLOC) ? S_ALC_RD : S_RESP;
                    end
                    else
                    begin
                        rd_pos  = n_next;
                        hp_next = n_next;
                    end
                end
            end
            S_ALC_RD:
            begin
                state_next = S_ALC_EV;
            end
            S_ALC_EV:
            begin
                largest_next = lg;
                if (hq.owner == OWNER_FREE && hq.size >= want_reg)
                begin
                    granted_next = 12'(p_reg + 14'd1);
                    largest_next = '0;
                    wr_en        = 1'b1;
                    if (hq.size > want_reg)
                    begin
                        wr_pos     = alc_r;
                        wr_hdr     = '{term: hq.term, owner: OWNER_FREE,
                                       size: hq.size - want_reg - 12'd1};
                        hp_next    = p_reg;
                        h_next     = '{term: 1'b0, owner: owner_reg, size: want_reg};
                        state_next = S_SPL_W2;
                    end
                    else
                    begin
                        wr_pos     = p_reg;
                        wr_hdr     = '{term: hq.term, owner: owner_reg, size: want_reg};
                        state_next = S_RESP;
                    end
                end
                else if (hq.term)
                begin
                    st_next    = ST_INSUFF;
                    state_next = S_RESP;
                end
                else
                begin
                    p_next     = h_end;
                    state_next = S_ALC_RD;
                end
            end
            S_SPL_W2:
            begin
                wr_en      = 1'b1;
                wr_pos     = hp_reg;
                wr_hdr     = '{term: 1'b0, owner: h_reg.owner, size: want_reg};
                p_next     = '0;
                state_next = (cmd_reg == CMD_ALLOC) ? S_RESP : S_COA_RD;
            end
            S_ISH_RD:
            begin
                state_next = (p_reg == hp_reg) ? S_BLK_RD : S_ISH_EV;
            end
            S_ISH_EV:
            begin
                if (hq.term || h_end >= t_pos)
                begin
                    st_next    = ST_BAD_BLOCK;
                    state_next = S_RESP;
                end
                else
                begin
                    p_next     = h_end;
                    state_next = S_ISH_RD;
                end
            end
            S_BLK_RD:
            begin
                rd_pos     = hp_reg;
                state_next = S_BLK_EV;
            end
            S_BLK_EV:
            begin
                h_next = hq;
                p_next = '0;
                if (hq.owner == OWNER_FREE
                    || (owner_reg != OWNER_ANY && hq.owner != owner_reg))
                begin
                    st_next    = ST_BAD_BLOCK;
                    state_next = S_RESP;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    wr_en      = 1'b1;
                    wr_pos     = hp_reg;
                    wr_hdr     = '{term: hq.term, owner: OWNER_FREE, size: hq.size};
                    state_next = S_COA_RD;
                end
                else if (want_reg < hq.size)
                begin
                    wr_en      = 1'b1;
                    wr_pos     = rsz_r;
                    wr_hdr     = '{term: hq.term, owner: OWNER_FREE,
                                   size: hq.size - want_reg - 12'd1};
                    state_next = S_SPL_W2;
                end
                else if (want_reg == hq.size)
                begin
                    state_next = S_RESP;
                end
                else if (hq.term)
                begin
                    st_next      = ST_INSUFF;
                    largest_next = hq.size;
                    state_next   = S_RESP;
                end
                else
                begin
                    rd_pos     = hp_end;
                    state_next = S_RSZ_NEV;
                end
            end
            S_RSZ_NEV:
            begin
                // Grow only into a free block that directly follows.
                if (hq.owner != OWNER_FREE)
                begin
                    st_next      = ST_INSUFF;
                    largest_next = h_reg.size;
                    state_next   = S_RESP;
                end
                else if (comb13 < {1'b0, want_reg})
                begin
                    st_next      = ST_INSUFF;
                    largest_next = 12'(comb13);
                    state_next   = S_RESP;
                end
                else if (comb13 > {1'b0, want_reg})
                begin
                    wr_en      = 1'b1;
                    wr_pos     = rsz_r;
                    wr_hdr     = '{term: hq.term, owner: OWNER_FREE,
                                   size: 12'(comb13 - {1'b0, want_reg} - 13'd1)};
                    state_next = S_SPL_W2;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_pos     = hp_reg;
                    wr_hdr     = '{term: hq.term, owner: h_reg.owner, size: 12'(comb13)};
                    state_next = S_COA_RD;
                end
            end
            S_FO_RD:
            begin
                state_next = S_FO_EV;
            end
            S_FO_EV:
            begin
                if (hq.owner == owner_reg)
                begin
                    wr_en      = 1'b1;
                    wr_pos     = p_reg;
                    wr_hdr     = '{term: hq.term, owner: OWNER_FREE, size: hq.size};
                    freed_next = freed_reg + 13'd1;
                end
                if (hq.term)
                begin
                    p_next     = '0;
                    state_next = (freed_next != 13'd0) ? S_COA_RD : S_RESP;
                end
                else
                begin
                    p_next     = h_end;
                    state_next = S_FO_RD;
                end
            end
            S_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{status: st_reg, granted_data_para: granted_reg,
                                       largest_free: largest_reg, freed_count: freed_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arena_reg     <= ARENA_RESET;
            res_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arena_reg     <= arena_next;
            res_valid_reg <= res_valid_next;
            rd_ok_reg     <= in_arena(rd_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        owner_reg    <= owner_next;
        want_reg     <= want_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        hp_reg       <= hp_next;
        h_reg        <= h_next;
        st_reg       <= st_next;
        granted_reg  <= granted_next;
        largest_reg  <= largest_next;
        freed_reg    <= freed_next;
        res_item_reg <= res_item_next;
    end

endmodule

### sv/pafa_checker.sv
// ============================================================================
// pafa_checker
// Port-level checks on the allocator's channels, bound to the top level.
// ============================================================================
module pafa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input logic                res_valid,
    input logic                res_stall,
    input pafa_pkg::res_item_t res_item
);
    import pafa_pkg::*;

    // A waiting result item stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result item dropped while stalled");

    // A waiting result item keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_item))
        else $error("result item changed while stalled");

    // One command at a time: an accepted item closes the command channel.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command channel open right after an accepted item");

    // A granted paragraph is only reported with an ok status.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.granted_data_para != 12'd0 |-> res_item.status == ST_OK)
        else $error("grant reported without ok status");

    // A largest-free figure is only reported with an insufficient status.
    a_largest_insuff: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.largest_free != 12'd0 |-> res_item.status == ST_INSUFF)
        else $error("largest free reported without insufficient status");

endmodule

bind paragraph_arena_first_fit_allocator_unit pafa_checker u_pafa_checker (.*);
